FILE: src/iirl_pkg.sv
// Package for the indexed insert/remove list: command and status codes,
// field widths and the control struct broadcast along the cell row.
// No dependencies.
package iirl_pkg;

  // Fixed widths of the channel fields.
  localparam int CmdW    = 2;
  localparam int PosW    = 6;
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int LengthW = 7;

  // Command codes carried in the cmd field.
  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_GET    = 2'd2,
    CMD_POP    = 2'd3
  } cmd_e;

  // Status codes returned with every result.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Shift control broadcast to every cell in the row.
  typedef struct packed {
    logic ins;  // open a gap at the position and load the new item
    logic pop;  // close the gap at the position
  } cell_ctrl_t;

endpackage

FILE: src/iirl_if.sv
// Channel interfaces of the indexed insert/remove list: the command channel
// and the result channel, each with valid/ready and its payload.
// Depends on iirl_pkg.
interface iirl_cmd_if;
  import iirl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [PosW-1:0]   position;
  logic [ValueW-1:0] item_value;

  modport source (output valid, cmd, position, item_value, input ready);
  modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface iirl_rsp_if;
  import iirl_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ValueW-1:0]  read_value;
  logic [LengthW-1:0] list_length;

  modport source (output valid, status, read_value, list_length, input ready);
  modport sink   (input valid, status, read_value, list_length, output ready);
endinterface

FILE: src/iirl_cell.sv
// One storage cell of the list row. It holds one entry and, on an insert or
// pop, takes the new item or the word of its left or right neighbor. Depends on iirl_pkg.
module iirl_cell import iirl_pkg::*; #(
  parameter int ItemW = 32,
  parameter int CmpW  = 7,
  parameter int Idx   = 0
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CmpW-1:0]  pos_i,
  input  logic [ItemW-1:0] item_i,
  input  logic [ItemW-1:0] left_i,
  input  logic [ItemW-1:0] right_i,
  output logic [ItemW-1:0] q_o,
  output logic [ItemW-1:0] rd_o
);

  localparam logic [CmpW-1:0] IdxC = CmpW'(Idx);

  logic [ItemW-1:0] entry_q, entry_d;
  logic             at_pos;
  logic             above_pos;

  assign at_pos    = (pos_i == IdxC);
  assign above_pos = (IdxC > pos_i);

  // Insert: the cell at the position loads the item, cells above take the
  // left neighbor. Pop: the cell at the position and those above take the
  // right neighbor. Cells past the end hold words that are never read.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        entry_d = item_i;
      end else if (above_pos) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.pop) begin
      if (at_pos || above_pos) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o  = entry_q;
  // Gated read so the row can be merged by a plain OR.
  assign rd_o = at_pos ? entry_q : '0;

endmodule

FILE: src/indexed_insert_remove_list.sv
// Indexed insert/remove list: an ordered list of up to CAPACITY words held in a
// row of cells, one entry per cell. Append, insert, get and pop each complete in
// the cycle the command transaction is accepted, since every cell shifts toward
// its neighbor in parallel; the result is registered and appears on the result
// channel in the following cycle, so one command is taken every cycle while the
// result side keeps up. The command channel stalls only while a result is held
// unread. Entries have no reset and need no clearing pass; only entries below
// the length are ever read. list_length reports the length modulo 128.
module indexed_insert_remove_list import iirl_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iirl_cmd_if.sink   cmd_i,
  iirl_rsp_if.source rsp_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [StatusW-1:0]    status_q;
  logic [ValueW-1:0]     read_value_q;
  logic [LengthW-1:0]    length_q;

  logic                  in_fire;
  logic [ITEM_WIDTH-1:0] item_w;
  logic [CmpW-1:0]       cnt_x, pos_x, cell_pos;
  logic                  full;
  cell_ctrl_t            ctrl;
  status_e               status_d;
  logic                  read_ok;
  logic [ITEM_WIDTH-1:0] cell_q  [CAPACITY];
  logic [ITEM_WIDTH-1:0] cell_rd [CAPACITY];
  logic [ITEM_WIDTH-1:0] rd_sel;

  assign cmd_i.ready = !out_valid_q || rsp_o.ready;
  assign in_fire     = cmd_i.valid && cmd_i.ready;

  assign item_w = ITEM_WIDTH'(cmd_i.item_value);
  assign cnt_x  = CmpW'(count_q);
  assign pos_x  = CmpW'(cmd_i.position);
  assign full   = (count_q >= CapC);

  // Command decode: status, shift control and next length.
  always_comb begin
    ctrl     = '0;
    status_d = ST_OK;
    read_ok  = 1'b0;
    cell_pos = pos_x;
    count_d  = count_q;
    unique case (cmd_e'(cmd_i.cmd))
      CMD_APPEND: begin
        cell_pos = cnt_x;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = in_fire;
          if (in_fire) count_d = count_q + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = in_fire;
          if (in_fire) count_d = count_q + 1'b1;
        end
      end
      CMD_GET: begin
        if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          read_ok  = 1'b1;
          ctrl.pop = in_fire;
          if (in_fire) count_d = count_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // Row of cells wired to neighbors; the item feeds cell 0 from the left.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = item_w;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    iirl_cell #(
      .ItemW (ITEM_WIDTH),
      .CmpW  (CmpW),
      .Idx   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (cell_pos),
      .item_i  (item_w),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (cell_q[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // Merge the gated cell reads; at most one cell matches the position.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  // Length and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q     <= status_d;
      read_value_q <= read_ok ? ValueW'(rd_sel) : '0;
      length_q     <= LengthW'(count_d);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_value  = read_value_q;
  assign rsp_o.list_length = length_q;

  // The length never passes the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("list length above capacity");

  // The length moves only when a command transaction is accepted.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(count_q))
    else $error("list length changed without a transaction");

  // An accepted command always leaves a result pending.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted command produced no result");

  // An error result carries a zero word.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> (read_value_q == '0))
    else $error("error result with nonzero read value");

endmodule
